// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is active.
`define LFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form built on the macro above.
`define LFP_ASSERT_IMPL(label, ante, cons, msg) \
  `LFP_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ----- rtl/lfp_pkg.sv -----
// Package of the lidar frame parser: frame layout constants, types, result format.
// No dependencies.
package lfp_pkg;

  localparam int unsigned SampleCount   = 270;
  localparam int unsigned MaxFrameBytes = 945;

  localparam int unsigned PosW  = $clog2(MaxFrameBytes + 1);
  localparam int unsigned IdxW  = 9;
  localparam int unsigned ValW  = 16;

  typedef logic [PosW-1:0] pos_t;

  localparam logic [7:0]  StartByte   = 8'h02;
  localparam logic [15:0] LengthShort = 16'd927;
  localparam logic [15:0] LengthLong  = 16'd936;
  localparam logic [15:0] NoneValue   = 16'hFFFF;

  localparam pos_t StartBytes = pos_t'(4);
  localparam pos_t LenHiPos   = pos_t'(6);
  localparam pos_t LenLoPos   = pos_t'(7);
  localparam pos_t MinPos     = pos_t'(936);
  localparam pos_t MaxPos     = pos_t'(MaxFrameBytes);
  localparam pos_t DistBegin  = pos_t'(87);
  localparam pos_t DistEnd    = pos_t'(87 + 2 * SampleCount);
  localparam pos_t StrBegin   = pos_t'(652);
  localparam pos_t StrEnd     = pos_t'(652 + SampleCount);

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    KIND_DISTANCE = 2'd0,
    KIND_STRENGTH = 2'd1,
    KIND_SUMMARY  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_START  = 2'd1,
    STATUS_BAD_LENGTH = 2'd2,
    STATUS_SHORT      = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    REG_DISTANCE_MIN = 1'b0,
    REG_DISTANCE_MAX = 1'b1
  } reg_idx_e;

  typedef struct packed {
    kind_e             result_kind;
    logic [IdxW-1:0]   sample_index;
    logic [ValW-1:0]   sample_value;
    status_e           frame_status;
    logic [15:0]       nearest_index;
    logic [15:0]       nearest_distance;
    logic [9:0]        frame_bytes;
    logic [31:0]       valid_frames;
    logic [31:0]       invalid_frames;
    logic              last_result;
  } result_t;

  typedef struct packed {
    logic [15:0] distance_min;
    logic [15:0] distance_max;
  } cfg_t;

  typedef struct packed {
    logic    sample_vld;
    result_t sample;
    logic    summary_vld;
    result_t summary;
  } push_t;

endpackage

// ----- rtl/lfp_stream_if.sv -----
// Valid/ready channel interfaces of the lidar frame parser.
// Depends on lfp_pkg for field widths.
interface lfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface lfp_out_if;
  import lfp_pkg::*;
  logic            valid;
  logic            ready;
  logic [1:0]      result_kind;
  logic [IdxW-1:0] sample_index;
  logic [ValW-1:0] sample_value;
  logic [1:0]      frame_status;
  logic [15:0]     nearest_index;
  logic [15:0]     nearest_distance;
  logic [9:0]      frame_bytes;
  logic [31:0]     valid_frames;
  logic [31:0]     invalid_frames;
  logic            last_result;

  modport source (output valid, output result_kind, output sample_index, output sample_value,
                  output frame_status, output nearest_index, output nearest_distance,
                  output frame_bytes, output valid_frames, output invalid_frames,
                  output last_result, input ready);
  modport sink   (input valid, input result_kind, input sample_index, input sample_value,
                  input frame_status, input nearest_index, input nearest_distance,
                  input frame_bytes, input valid_frames, input invalid_frames,
                  input last_result, output ready);
endinterface

// ----- rtl/lidar_frame_parser.sv -----
// Lidar frame parser top level: channels, limit registers, parser and result queue.
// Depends on lfp_pkg, lfp_stream_if, lfp_parser, lfp_result_fifo, assert_macros.svh.
//
// Usage: req_i carries one frame byte per request (data_byte, frame_end on the
// last byte of a frame). res_o carries results: distance samples, strength
// samples and one frame summary on the closing byte; last_result marks the
// final result of a byte. A byte gives zero, one or two results.
// Results of a byte are registered into the result queue and leave on res_o in order.
// Throughput: one byte per cycle; the result queue holds four entries and
// req_i.ready drops only while fewer than two are free, which happens only
// when the receiver stalls res_o. The closing byte may queue two results.
// Configuration: APB writes at 0x0 (distance_min) and 0x4 (distance_max),
// written while no byte is in flight.
// Reset: limits return to 90 and 3600, frame state and counters clear, the
// result queue empties.
module lidar_frame_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  lfp_in_if.sink       req_i,
  lfp_out_if.source    res_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import lfp_pkg::*;

  cfg_t    cfg_q, cfg_d;
  push_t   push;
  result_t head;
  logic    room, head_vld, accept, cfg_we;
  reg_idx_e reg_idx;

  assign reg_idx = reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    case (reg_idx)
      REG_DISTANCE_MIN: prdata = {16'h0000, cfg_q.distance_min};
      REG_DISTANCE_MAX: prdata = {16'h0000, cfg_q.distance_max};
      default:          prdata = '0;
    endcase
    if (cfg_we) begin
      case (reg_idx)
        REG_DISTANCE_MIN: cfg_d.distance_min = pwdata[15:0];
        REG_DISTANCE_MAX: cfg_d.distance_max = pwdata[15:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.distance_min <= 16'd90;
      cfg_q.distance_max <= 16'd3600;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign req_i.ready = room;
  assign accept      = req_i.valid && room;

  lfp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .byte_i   (req_i.data_byte),
    .last_i   (req_i.frame_end),
    .push_o   (push)
  );

  lfp_result_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .head_vld_o (head_vld),
    .head_o     (head),
    .pop_i      (res_o.ready)
  );

  assign res_o.valid            = head_vld;
  assign res_o.result_kind      = head.result_kind;
  assign res_o.sample_index     = head.sample_index;
  assign res_o.sample_value     = head.sample_value;
  assign res_o.frame_status     = head.frame_status;
  assign res_o.nearest_index    = head.nearest_index;
  assign res_o.nearest_distance = head.nearest_distance;
  assign res_o.frame_bytes      = head.frame_bytes;
  assign res_o.valid_frames     = head.valid_frames;
  assign res_o.invalid_frames   = head.invalid_frames;
  assign res_o.last_result      = head.last_result;

`include "assert_macros.svh"

  `LFP_ASSERT_IMPL(a_summary_last, head_vld && head.result_kind == KIND_SUMMARY, head.last_result, "summary without last_result")
  `LFP_ASSERT_IMPL(a_sample_fields, head_vld && head.result_kind != KIND_SUMMARY, head.frame_bytes == '0 && head.valid_frames == '0, "sample carries summary fields")
  `LFP_ASSERT_IMPL(a_sample_index, head_vld && head.result_kind != KIND_SUMMARY, head.sample_index < IdxW'(SampleCount), "sample index out of range")
  `LFP_ASSERT_IMPL(a_push_room, push.sample_vld || push.summary_vld, room, "result pushed without queue room")

endmodule

// ----- rtl/lfp_parser.sv -----
// Per-byte frame parser: frame state, sample extraction, nearest tracking, summary.
// Depends on lfp_pkg.
module lfp_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  lfp_pkg::cfg_t cfg_i,
  input  logic         accept_i,
  input  logic [7:0]   byte_i,
  input  logic         last_i,
  output lfp_pkg::push_t push_o
);
  import lfp_pkg::*;

  pos_t        pos_q, pos_d, pos_u;
  logic        start_bad_q, start_bad_d, start_bad_u;
  logic [15:0] len_q, len_d, len_u;
  logic [7:0]  hi_q, hi_d, hi_u;
  logic [15:0] best_dist_q, best_dist_d, best_dist_u;
  logic [15:0] best_idx_q, best_idx_d, best_idx_u;
  logic [31:0] good_q, good_d;
  logic [31:0] bad_q, bad_d;

  pos_t        rel_dist, rel_str;
  logic [15:0] dist_val;
  logic        sample_vld;
  result_t     sample, summary;
  status_e     status;

  always_comb begin
    pos_u       = pos_q;
    start_bad_u = start_bad_q;
    len_u       = len_q;
    hi_u        = hi_q;
    best_dist_u = best_dist_q;
    best_idx_u  = best_idx_q;
    sample_vld  = 1'b0;
    sample      = '0;
    rel_dist    = pos_q - DistBegin;
    rel_str     = pos_q - StrBegin;
    dist_val    = {hi_q, byte_i};

    if (pos_q < MaxPos) begin
      if (pos_q < StartBytes && byte_i != StartByte) begin
        start_bad_u = 1'b1;
      end
      if (pos_q == LenHiPos) begin
        len_u = {byte_i, len_q[7:0]};
      end
      if (pos_q == LenLoPos) begin
        len_u = {len_q[15:8], byte_i};
      end
      if (pos_q >= DistBegin && pos_q < DistEnd) begin
        if (!rel_dist[0]) begin
          hi_u = byte_i;
        end else begin
          if (dist_val < best_dist_q && dist_val > cfg_i.distance_min &&
              dist_val < cfg_i.distance_max)
          begin
            best_dist_u = dist_val;
            best_idx_u  = 16'(rel_dist >> 1);
          end
          sample_vld          = 1'b1;
          sample.result_kind  = KIND_DISTANCE;
          sample.sample_index = IdxW'(rel_dist >> 1);
          sample.sample_value = dist_val;
        end
      end
      if (pos_q >= StrBegin && pos_q < StrEnd) begin
        sample_vld          = 1'b1;
        sample.result_kind  = KIND_STRENGTH;
        sample.sample_index = IdxW'(rel_str);
        sample.sample_value = {8'h00, byte_i};
      end
      pos_u = pos_q + pos_t'(1);
    end
    sample.last_result = !last_i;

    if (start_bad_u) begin
      status = STATUS_BAD_START;
    end else if (len_u != LengthShort && len_u != LengthLong) begin
      status = STATUS_BAD_LENGTH;
    end else if (pos_u < MinPos) begin
      status = STATUS_SHORT;
    end else begin
      status = STATUS_OK;
    end

    good_d = good_q;
    bad_d  = bad_q;
    if (last_i) begin
      if (status == STATUS_OK) begin
        good_d = good_q + 32'd1;
      end else begin
        bad_d = bad_q + 32'd1;
      end
    end

    summary                  = '0;
    summary.result_kind      = KIND_SUMMARY;
    summary.frame_status     = status;
    summary.nearest_index    = (status == STATUS_OK) ? best_idx_u : NoneValue;
    summary.nearest_distance = (status == STATUS_OK) ? best_dist_u : NoneValue;
    summary.frame_bytes      = 10'(pos_u);
    summary.valid_frames     = good_d;
    summary.invalid_frames   = bad_d;
    summary.last_result      = 1'b1;

    if (last_i) begin
      pos_d       = '0;
      start_bad_d = 1'b0;
      len_d       = '0;
      hi_d        = '0;
      best_dist_d = NoneValue;
      best_idx_d  = NoneValue;
    end else begin
      pos_d       = pos_u;
      start_bad_d = start_bad_u;
      len_d       = len_u;
      hi_d        = hi_u;
      best_dist_d = best_dist_u;
      best_idx_d  = best_idx_u;
    end
  end

  assign push_o.sample_vld  = accept_i && sample_vld;
  assign push_o.sample      = sample;
  assign push_o.summary_vld = accept_i && last_i;
  assign push_o.summary     = summary;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      start_bad_q <= 1'b0;
      len_q       <= '0;
      hi_q        <= '0;
      best_dist_q <= NoneValue;
      best_idx_q  <= NoneValue;
      good_q      <= '0;
      bad_q       <= '0;
    end else if (accept_i) begin
      pos_q       <= pos_d;
      start_bad_q <= start_bad_d;
      len_q       <= len_d;
      hi_q        <= hi_d;
      best_dist_q <= best_dist_d;
      best_idx_q  <= best_idx_d;
      good_q      <= good_d;
      bad_q       <= bad_d;
    end
  end

endmodule

// ----- rtl/lfp_result_fifo.sv -----
// Result queue: takes up to two results per cycle while room_o is high, hands out one per cycle while pop_i is high.
// Depends on lfp_pkg.
module lfp_result_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lfp_pkg::push_t   push_i,
  output logic             room_o,
  output logic             head_vld_o,
  output lfp_pkg::result_t head_o,
  input  logic             pop_i
);
  import lfp_pkg::*;

  result_t mem_q [FifoDepth];

  logic [FifoPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic [1:0]          n_push;
  logic                pop;
  result_t             entry0;

  assign n_push = {1'b0, push_i.sample_vld} + {1'b0, push_i.summary_vld};
  assign entry0 = push_i.sample_vld ? push_i.sample : push_i.summary;
  assign pop    = pop_i && head_vld_o;

  assign wr_d  = wr_q + FifoPtrW'(n_push);
  assign rd_d  = rd_q + FifoPtrW'(pop);
  assign cnt_d = cnt_q + FifoCntW'(n_push) - FifoCntW'(pop);

  assign room_o     = cnt_q <= FifoCntW'(FifoDepth - 2);
  assign head_vld_o = cnt_q != '0;
  assign head_o     = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_q] <= entry0;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_q + FifoPtrW'(1)] <= push_i.summary;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for lidar_frame_parser: byte stream in, samples and summaries out.
// Depends on lfp_pkg, lfp_stream_if and the RTL; predicts every result and compares in order.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lfp_pkg::*;

  localparam int unsigned RandomBytes = 1650;
  localparam int unsigned PhaseBytes  = 413;
  localparam int unsigned CycleLimit  = 400000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  lfp_in_if  req_if();
  lfp_out_if res_if();

  lidar_frame_parser i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  byte_item_t  tx_bytes[$];
  result_t     due_results[$];
  bit          byte_taken;
  bit          recv_hold;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned random_sent;
  bit          counting;
  int unsigned phase;

  // parser state mirror
  logic [15:0] lim_min, lim_max;
  pos_t        fp_pos;
  logic        fp_start_bad;
  logic [15:0] fp_len;
  logic [7:0]  fp_dist_hi;
  logic [15:0] fp_best_dist, fp_best_idx;
  logic [31:0] fp_good, fp_bad;

  task automatic clear_frame();
    fp_pos = '0;
    fp_start_bad = 1'b0;
    fp_len = '0;
    fp_dist_hi = '0;
    fp_best_dist = NoneValue;
    fp_best_idx = NoneValue;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last);
    result_t     r[2];
    int          n;
    pos_t        rel;
    logic [15:0] d;
    status_e     st;
    n = 0;
    if (fp_pos < MaxPos) begin
      if (fp_pos < StartBytes && b != StartByte) fp_start_bad = 1'b1;
      if (fp_pos == LenHiPos) fp_len[15:8] = b;
      if (fp_pos == LenLoPos) fp_len[7:0] = b;
      if (fp_pos >= DistBegin && fp_pos < DistEnd) begin
        rel = fp_pos - DistBegin;
        if (!rel[0]) begin
          fp_dist_hi = b;
        end else begin
          d = {fp_dist_hi, b};
          if (d < fp_best_dist && d > lim_min && d < lim_max) begin
            fp_best_dist = d;
            fp_best_idx = 16'(rel >> 1);
          end
          r[n] = '0;
          r[n].result_kind = KIND_DISTANCE;
          r[n].sample_index = IdxW'(rel >> 1);
          r[n].sample_value = d;
          n++;
        end
      end
      if (fp_pos >= StrBegin && fp_pos < StrEnd) begin
        r[n] = '0;
        r[n].result_kind = KIND_STRENGTH;
        r[n].sample_index = IdxW'(fp_pos - StrBegin);
        r[n].sample_value = {8'h00, b};
        n++;
      end
      fp_pos = fp_pos + 1'b1;
    end
    if (last) begin
      if (fp_start_bad) st = STATUS_BAD_START;
      else if (fp_len != LengthShort && fp_len != LengthLong) st = STATUS_BAD_LENGTH;
      else if (fp_pos < MinPos) st = STATUS_SHORT;
      else st = STATUS_OK;
      if (st == STATUS_OK) fp_good++;
      else fp_bad++;
      r[n] = '0;
      r[n].result_kind = KIND_SUMMARY;
      r[n].frame_status = st;
      r[n].nearest_index = (st == STATUS_OK) ? fp_best_idx : NoneValue;
      r[n].nearest_distance = (st == STATUS_OK) ? fp_best_dist : NoneValue;
      r[n].frame_bytes = 10'(fp_pos);
      r[n].valid_frames = fp_good;
      r[n].invalid_frames = fp_bad;
      n++;
      clear_frame();
    end
    if (n > 0) r[n-1].last_result = 1'b1;
    for (int i = 0; i < n; i++) due_results.push_back(r[i]);
  endtask

  task automatic flag_mismatch(input string msg);
    if (mismatches < 50) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // accepted bytes feed the predictor, accepted results are checked
  always @(posedge clk_i) begin
    result_t seen, want;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        parse_byte(req_if.data_byte, req_if.frame_end);
        void'(tx_bytes.pop_front());
        byte_taken = 1'b1;
      end
      if (res_if.valid && res_if.ready) begin
        seen.result_kind = kind_e'(res_if.result_kind);
        seen.sample_index = res_if.sample_index;
        seen.sample_value = res_if.sample_value;
        seen.frame_status = status_e'(res_if.frame_status);
        seen.nearest_index = res_if.nearest_index;
        seen.nearest_distance = res_if.nearest_distance;
        seen.frame_bytes = res_if.frame_bytes;
        seen.valid_frames = res_if.valid_frames;
        seen.invalid_frames = res_if.invalid_frames;
        seen.last_result = res_if.last_result;
        if (due_results.size() == 0) begin
          flag_mismatch("result with no request pending");
        end else begin
          want = due_results.pop_front();
          check_field("result_kind", 32'(seen.result_kind), 32'(want.result_kind));
          check_field("sample_index", 32'(seen.sample_index), 32'(want.sample_index));
          check_field("sample_value", 32'(seen.sample_value), 32'(want.sample_value));
          check_field("frame_status", 32'(seen.frame_status), 32'(want.frame_status));
          check_field("nearest_index", 32'(seen.nearest_index), 32'(want.nearest_index));
          check_field("nearest_distance", 32'(seen.nearest_distance),
                      32'(want.nearest_distance));
          check_field("frame_bytes", 32'(seen.frame_bytes), 32'(want.frame_bytes));
          check_field("valid_frames", seen.valid_frames, want.valid_frames);
          check_field("invalid_frames", seen.invalid_frames, want.invalid_frames);
          check_field("last_result", 32'(seen.last_result), 32'(want.last_result));
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_if.valid || byte_taken) begin
        byte_taken = 1'b0;
        if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_if.valid <= 1'b1;
          req_if.data_byte <= tx_bytes[0].data;
          req_if.frame_end <= tx_bytes[0].last;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      res_if.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_limit(input reg_idx_e idx, input logic [15:0] val);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = {16'h0000, val};
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (idx == REG_DISTANCE_MIN) lim_min = val;
    else lim_max = val;
  endtask

  task automatic drain();
    while (tx_bytes.size() != 0 || req_if.valid) @(negedge clk_i);
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic next_phase();
    logic [15:0] lo;
    drain();
    phase++;
    case (phase)
      1: begin
        send_idle_pct = 73;
        recv_stall_pct = 0;
        lo = 16'($urandom_range(0, 2000));
        write_limit(REG_DISTANCE_MIN, lo);
        write_limit(REG_DISTANCE_MAX, 16'($urandom_range(lo + 1, 65535)));
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 73;
        write_limit(REG_DISTANCE_MIN, 16'hFFFF);
        write_limit(REG_DISTANCE_MAX, 16'h0000);
      end
      default: begin
        send_idle_pct = 17;
        recv_stall_pct = 17;
        write_limit(REG_DISTANCE_MIN, 16'd90);
        write_limit(REG_DISTANCE_MAX, 16'd3600);
      end
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    tx_bytes.push_back('{data: b, last: last});
    if (counting) begin
      random_sent++;
      if (random_sent % PhaseBytes == 0 && phase < 3) next_phase();
    end
  endtask

  function automatic logic [15:0] pick_distance();
    case ($urandom_range(7))
      0: return lim_min;
      1: return lim_min + 16'd1;
      2: return lim_max;
      3: return lim_max - 16'd1;
      4: return 16'h0000;
      5: return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic send_frame(input int unsigned flen, input bit bad_start, input bit bad_len);
    logic [15:0] lenf;
    logic [15:0] d;
    logic [7:0]  b;
    int unsigned bad_pos;
    int unsigned p;
    lenf = $urandom_range(1) ? LengthShort : LengthLong;
    if (bad_len) begin
      lenf = 16'($urandom_range(65535));
      if (lenf == LengthShort || lenf == LengthLong) lenf = 16'h0000;
    end
    bad_pos = $urandom_range(3);
    d = '0;
    for (p = 0; p < flen; p++) begin
      b = 8'($urandom_range(255));
      if (p < 4) begin
        b = StartByte;
        if (bad_start && p == bad_pos) begin
          b = 8'($urandom_range(255));
          if (b == StartByte) b = 8'h03;
        end
      end else if (p == 6) begin
        b = lenf[15:8];
      end else if (p == 7) begin
        b = lenf[7:0];
      end else if (p >= DistBegin && p < DistEnd) begin
        if ((p - DistBegin) % 2 == 0) begin
          d = pick_distance();
          b = d[15:8];
        end else begin
          b = d[7:0];
        end
      end
      push_byte(b, p == flen - 1);
    end
  endtask

  initial begin
    int unsigned sel;
    int unsigned n;
    req_if.valid = 1'b0;
    req_if.data_byte = '0;
    req_if.frame_end = 1'b0;
    res_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    lim_min = 16'd90;
    lim_max = 16'd3600;
    clear_frame();
    fp_good = '0;
    fp_bad = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    write_limit(REG_DISTANCE_MIN, 16'h0000);
    write_limit(REG_DISTANCE_MAX, 16'hFFFF);

    // one-byte frames, header-only frames, bad start late in the header
    push_byte(8'h00, 1'b1);
    push_byte(8'h02, 1'b1);
    push_byte(8'h02, 1'b0); push_byte(8'h02, 1'b0); push_byte(8'h02, 1'b0);
    push_byte(8'h02, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h03, 1'b0); push_byte(8'hA7, 1'b1);
    push_byte(8'h02, 1'b0); push_byte(8'h02, 1'b0); push_byte(8'h02, 1'b0);
    push_byte(8'h02, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'h03, 1'b0); push_byte(8'hA8, 1'b1);
    push_byte(8'h02, 1'b0); push_byte(8'h02, 1'b0); push_byte(8'h02, 1'b0);
    push_byte(8'hFF, 1'b1);
    drain();

    // long receiver hold while the sender keeps offering
    fork
      begin
        recv_hold = 1'b1;
        repeat (300) @(posedge clk_i);
        recv_hold = 1'b0;
      end
    join_none

    counting = 1'b1;
    while (random_sent < RandomBytes) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        send_frame(($urandom_range(9) == 0) ? $urandom_range(946, 980)
                                            : $urandom_range(936, 945), 1'b0, 1'b0);
      end else if (sel < 60) begin
        send_frame($urandom_range(8, 935), 1'b0, 1'b0);
      end else if (sel < 72) begin
        send_frame(($urandom_range(4) == 0) ? $urandom_range(936, 945)
                                            : $urandom_range(1, 60), 1'b1, 1'b0);
      end else if (sel < 84) begin
        send_frame(($urandom_range(4) == 0) ? $urandom_range(936, 945)
                                            : $urandom_range(8, 60), 1'b0, 1'b1);
      end else begin
        n = $urandom_range(1, 30);
        for (int unsigned k = 1; k <= n; k++) push_byte(8'($urandom_range(255)), k == n);
      end
    end
    drain();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
